### rtl/tfp_pkg.sv
// ---------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants of the temperature frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int READ_W      = 16;
    localparam int WHOLE_W     = 10;
    localparam int HUND_W      = 8;
    localparam int POS_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_DATA_W  = 40;

    // frame positions
    localparam logic [POS_W-1:0] POS_HDR0  = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR1  = 4'd1;
    localparam logic [POS_W-1:0] POS_TYPE  = 4'd2;
    localparam logic [POS_W-1:0] POS_SIZE  = 4'd3;
    localparam logic [POS_W-1:0] POS_TGT_H = 4'd4;
    localparam logic [POS_W-1:0] POS_TGT_L = 4'd5;
    localparam logic [POS_W-1:0] POS_AMB_H = 4'd6;
    localparam logic [POS_W-1:0] POS_AMB_L = 4'd7;
    localparam logic [POS_W-1:0] POS_SUM   = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_RST = 8'd90;
    localparam logic [BYTE_W-1:0] TYPE_RST   = 8'd69;
    localparam logic [BYTE_W-1:0] SIZE_RST   = 8'd4;

    // x / 100 == (x * 5243) >> 19, exact for 0 <= x <= 43690
    localparam int SCALE     = 100;
    localparam int DIV_RECIP = 5243;
    localparam int DIV_SHIFT = 19;
    localparam int PROD_W    = 29;
    localparam int Q_W       = 9;
    localparam int REM_W     = 7;

    typedef struct packed {
        logic signed [WHOLE_W-1:0] whole;
        logic signed [HUND_W-1:0]  hundredths;
    } t_reading;

endpackage

`default_nettype wire

### rtl/temperature_frame_parser.sv
// ---------------------------------------------------------------------------
// temperature_frame_parser
// Frame parser for an infrared temperature sensor byte stream.
// ---------------------------------------------------------------------------
// Takes one byte per beat, one beat per clock while s_axis_tready is high,
// and hunts for two header bytes, then takes type, size, two big-endian
// readings and an 8-bit sum. A frame whose type, size and sum match gives
// one result beat with target and ambient split into whole degrees and
// signed hundredths; a bad frame gives nothing and hunting restarts. The
// result leaves through a parser stage, a divide-by-100 stage and the
// output register. s_axis_tready drops only when all three stages hold
// a result and the output is stalled. Registers are written through the
// cfg port, which is always ready; index 3 is ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module temperature_frame_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream: [7:0] rx_byte
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tfp_pkg::BYTE_W-1:0]        s_axis_tdata,
    // master stream: [9:0] target_whole, [17:10] target_hundredths,
    // [27:18] ambient_whole, [35:28] ambient_hundredths, [39:36] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tfp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // register write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tfp_pkg::BYTE_W-1:0]        i_cfg_data
);
    import tfp_pkg::*;

    logic [BYTE_W-1:0] r_header, r_exp_type, r_exp_size;
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_sum, r_type, r_size;
    logic [READ_W-1:0] r_tgt, r_amb;
    logic              r_p_valid, r_m_valid, r_o_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic o_en, m_en, p_en, accept, frame_ok, frame_done;
    logic [BYTE_W-1:0] byte_in;
    t_reading tgt_rd, amb_rd;

    assign o_en   = !r_o_valid || m_axis_tready;
    assign m_en   = !r_m_valid || o_en;
    assign p_en   = !r_p_valid || m_en;
    assign accept = s_axis_tvalid && p_en;
    assign byte_in = s_axis_tdata;

    assign s_axis_tready = p_en;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= HEADER_RST;
            r_exp_type <= TYPE_RST;
            r_exp_size <= SIZE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEADER: r_header   <= i_cfg_data;
                REG_TYPE:   r_exp_type <= i_cfg_data;
                REG_SIZE:   r_exp_size <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign frame_ok = (r_type == r_exp_type) && (r_size == r_exp_size)
                   && (r_sum == byte_in);
    assign frame_done = accept && (r_pos == POS_SUM);

    // parser stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HDR0;
        end else if (accept) begin
            unique case (r_pos)
                POS_HDR1:  if (byte_in == r_header) r_pos <= POS_TYPE;
                POS_TYPE:  r_pos <= POS_SIZE;
                POS_SIZE:  r_pos <= POS_TGT_H;
                POS_TGT_H: r_pos <= POS_TGT_L;
                POS_TGT_L: r_pos <= POS_AMB_H;
                POS_AMB_H: r_pos <= POS_AMB_L;
                POS_AMB_L: r_pos <= POS_SUM;
                POS_SUM:   r_pos <= POS_HDR0;
                // first header position, and any stray code
                default:   r_pos <= (byte_in == r_header) ? POS_HDR1 : POS_HDR0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            unique case (r_pos)
                POS_HDR1:  if (byte_in == r_header) r_sum <= r_sum + byte_in;
                POS_TYPE:  begin r_type <= byte_in; r_sum <= r_sum + byte_in; end
                POS_SIZE:  begin r_size <= byte_in; r_sum <= r_sum + byte_in; end
                POS_TGT_H: begin r_tgt[15:8] <= byte_in; r_sum <= r_sum + byte_in; end
                POS_TGT_L: begin r_tgt[7:0]  <= byte_in; r_sum <= r_sum + byte_in; end
                POS_AMB_H: begin r_amb[15:8] <= byte_in; r_sum <= r_sum + byte_in; end
                POS_AMB_L: begin r_amb[7:0]  <= byte_in; r_sum <= r_sum + byte_in; end
                POS_SUM:   ;
                default:   r_sum <= byte_in;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_en) r_p_valid <= frame_done && frame_ok;
            if (m_en) r_m_valid <= r_p_valid;
            if (o_en) r_o_valid <= r_m_valid;
        end
    end

    tfp_split u_split_tgt (
        .i_clk     (i_clk),
        .i_en      (m_en),
        .i_raw     (r_tgt),
        .o_reading (tgt_rd)
    );

    tfp_split u_split_amb (
        .i_clk     (i_clk),
        .i_en      (m_en),
        .i_raw     (r_amb),
        .o_reading (amb_rd)
    );

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_out <= {4'd0, amb_rd.hundredths, amb_rd.whole,
                      tgt_rd.hundredths, tgt_rd.whole};
        end
    end

endmodule

`default_nettype wire

### rtl/tfp_split.sv
// ---------------------------------------------------------------------------
// tfp_split
// Splits a signed reading in hundredths into a truncated whole part and a
// remainder carrying the sign of the reading. One register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module tfp_split (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [tfp_pkg::READ_W-1:0]     i_raw,
    output tfp_pkg::t_reading              o_reading
);
    import tfp_pkg::*;

    logic              r_neg;
    logic [READ_W-1:0] r_mag;
    logic [Q_W-1:0]    r_q;

    logic [READ_W-1:0] n_mag;
    logic [PROD_W-1:0] n_prod;
    logic [READ_W-1:0] rem_full;
    logic [REM_W-1:0]  rem;
    logic [WHOLE_W-1:0] whole_mag;
    logic [HUND_W-1:0]  hund_mag;

    always_comb begin
        // magnitude; -32768 maps to 0x8000 which is still correct unsigned
        n_mag  = i_raw[READ_W-1] ? (~i_raw + 16'd1) : i_raw;
        n_prod = PROD_W'(n_mag) * PROD_W'(DIV_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_raw[READ_W-1];
            r_mag <= n_mag;
            r_q   <= n_prod[DIV_SHIFT +: Q_W];
        end
    end

    always_comb begin
        rem_full  = r_mag - (READ_W'(r_q) * READ_W'(SCALE));
        rem       = rem_full[REM_W-1:0];
        whole_mag = {{(WHOLE_W-Q_W){1'b0}}, r_q};
        hund_mag  = {{(HUND_W-REM_W){1'b0}}, rem};
        o_reading.whole      = r_neg ? (~whole_mag + 10'd1) : whole_mag;
        o_reading.hundredths = r_neg ? (~hund_mag + 8'd1) : hund_mag;
    end

endmodule

`default_nettype wire

### rtl/tfp_checker.sv
// ---------------------------------------------------------------------------
// tfp_checker
// Port-level checks of the temperature frame parser, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tfp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tfp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import tfp_pkg::*;

    logic signed [WHOLE_W-1:0] tw;
    logic signed [HUND_W-1:0]  th;

    assign tw = m_axis_tdata[9:0];
    assign th = m_axis_tdata[17:10];

    // an empty output register means the whole pipeline can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_hund_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (th >= -8'sd99) && (th <= 8'sd99))
        else $error("hundredths out of range");

    a_sign_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (tw != 10'sd0) && (th != 8'sd0) |-> (tw[9] == th[7]))
        else $error("whole and hundredths signs differ");

endmodule

bind temperature_frame_parser tfp_checker u_tfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
